>>> rtl/core/tlc_pkg.sv
// shared types, register indexes, reset values and decode functions
// for the traffic light controller; no dependencies
package tlc_pkg;

	typedef enum logic [1:0] {
		PH_NS_GO   = 2'd0,
		PH_NS_WARN = 2'd1,
		PH_EW_GO   = 2'd2,
		PH_EW_WARN = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_NS_GREEN = 3'd0,
		REG_NS_YELLOW = 3'd1,
		REG_EW_GREEN = 3'd2,
		REG_EW_YELLOW = 3'd3,
		REG_TICKS_SEC = 3'd4,
		REG_TICKS_BLINK = 3'd5,
		REG_DEBOUNCE = 3'd6,
		REG_NONE = 3'd7
	} reg_index_t;

	localparam logic [6:0]  RstNsGreen = 7'd20;
	localparam logic [3:0]  RstNsYellow = 4'd3;
	localparam logic [6:0]  RstEwGreen = 7'd15;
	localparam logic [3:0]  RstEwYellow = 4'd3;
	localparam logic [15:0] RstTicksSec = 16'd1000;
	localparam logic [15:0] RstTicksBlink = 16'd500;
	localparam logic [7:0]  RstDebounce = 8'd20;
	localparam logic [6:0]  RstSeconds = 7'd23;

	localparam logic [7:0] SegZero = 8'hC0;
	localparam logic [7:0] SegBlank = 8'hFF;

	// active-low pattern, blank above nine
	function automatic logic [7:0] digit_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'hC0;
			4'd1: p = 8'hF9;
			4'd2: p = 8'hA4;
			4'd3: p = 8'hB0;
			4'd4: p = 8'h99;
			4'd5: p = 8'h92;
			4'd6: p = 8'h82;
			4'd7: p = 8'hF8;
			4'd8: p = 8'h80;
			4'd9: p = 8'h90;
			default: p = SegBlank;
		endcase
		return p;
	endfunction

	// green plus yellow, saturated to the countdown width
	function automatic logic [6:0] load_value(input logic [6:0] green, input logic [3:0] yellow);
		logic [7:0] t;
		t = {1'b0, green} + {4'b0, yellow};
		return t[7] ? 7'd127 : t[6:0];
	endfunction

endpackage

>>> rtl/core/tlc_display.sv
// seven-segment digit decode for the countdown display
// depends on tlc_pkg
module tlc_display (
	input  logic [6:0] seconds_left,
	input  logic       units_sel,
	input  logic       emergency,
	output logic [7:0] segments
);

	logic [17:0] prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  units;

	// divide by ten through a reciprocal, exact below 128
	assign prod = {11'd0, seconds_left} * 18'd205;
	assign tens = prod[14:11];
	assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign units = seconds_left - tens_x10;

	always_comb begin
		if (emergency) begin
			segments = tlc_pkg::SegZero;
		end else if (units_sel) begin
			segments = tlc_pkg::digit_pattern(units[3:0]);
		end else begin
			segments = tlc_pkg::digit_pattern(tens);
		end
	end

endmodule

>>> rtl/core/traffic_light_controller.sv
// four-phase traffic light controller top level, one tick per input transfer
// depends on tlc_pkg and tlc_display
// the result of a tick is registered in the output register at its accepting edge
// throughput: one tick per cycle; the single output register holds back input
// only while its result waits for m_tready
// reset: arst_n resets all state but the output data and user registers, config returns to default times and dividers
module traffic_light_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // key_down
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // ns_red_on, ns_yellow_on, ns_green_on, ew_red_on,
	                               // ew_yellow_on, ew_green_on, segments, emergency_active
	output logic [1:0]  m_tuser    // digit_select
);

	logic [6:0]  ns_green_q, ew_green_q;
	logic [3:0]  ns_yellow_q, ew_yellow_q;
	logic [15:0] ticks_sec_q, ticks_blink_q;
	logic [7:0]  debounce_q;

	tlc_pkg::phase_t phase_q, phase_d;
	logic [6:0]  seconds_q, seconds_d;
	logic [15:0] ms_q, ms_d, blink_cnt_q, blink_cnt_d;
	logic        blink_q, blink_d, pending_q, pending_d;
	logic [1:0]  scan_q;
	logic        emerg_q, emerg_d, key_prev_q;
	logic [7:0]  release_q, release_d, release_inc, limit;
	logic [15:0] ms_inc, blink_inc;
	logic [6:0]  sec_dec;
	logic        key, accept;

	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic [1:0]  out_user_q;
	logic [7:0]  segments;
	logic [5:0]  lamps;

	assign key = s_tdata[0];
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_green_q <= tlc_pkg::RstNsGreen;
			ns_yellow_q <= tlc_pkg::RstNsYellow;
			ew_green_q <= tlc_pkg::RstEwGreen;
			ew_yellow_q <= tlc_pkg::RstEwYellow;
			ticks_sec_q <= tlc_pkg::RstTicksSec;
			ticks_blink_q <= tlc_pkg::RstTicksBlink;
			debounce_q <= tlc_pkg::RstDebounce;
		end else if (cfg_we) begin
			case (tlc_pkg::reg_index_t'(cfg_index))
				tlc_pkg::REG_NS_GREEN: ns_green_q <= cfg_data[6:0];
				tlc_pkg::REG_NS_YELLOW: ns_yellow_q <= cfg_data[3:0];
				tlc_pkg::REG_EW_GREEN: ew_green_q <= cfg_data[6:0];
				tlc_pkg::REG_EW_YELLOW: ew_yellow_q <= cfg_data[3:0];
				tlc_pkg::REG_TICKS_SEC: ticks_sec_q <= cfg_data;
				tlc_pkg::REG_TICKS_BLINK: ticks_blink_q <= cfg_data;
				tlc_pkg::REG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// next state of one tick
	always_comb begin
		ms_inc = ms_q + 16'd1;
		pending_d = pending_q;
		if (ms_inc == 16'd0 || ms_inc >= ticks_sec_q) begin
			ms_d = 16'd0;
			pending_d = 1'b1;
		end else begin
			ms_d = ms_inc;
		end

		blink_inc = blink_cnt_q + 16'd1;
		blink_d = blink_q;
		if (blink_inc == 16'd0 || blink_inc >= ticks_blink_q) begin
			blink_cnt_d = 16'd0;
			blink_d = !blink_q;
		end else begin
			blink_cnt_d = blink_inc;
		end

		emerg_d = emerg_q;
		release_d = 8'd0;
		release_inc = (release_q == 8'hFF) ? release_q : release_q + 8'd1;
		limit = (debounce_q == 8'd0) ? 8'd1 : debounce_q;
		if (key && !key_prev_q) begin
			emerg_d = !emerg_q;
		end else if (emerg_q && !key) begin
			if (release_inc >= limit) begin
				emerg_d = 1'b0;
			end else begin
				release_d = release_inc;
			end
		end

		phase_d = phase_q;
		seconds_d = seconds_q;
		sec_dec = (seconds_q == 7'd0) ? 7'd0 : seconds_q - 7'd1;
		if (!emerg_d && pending_d) begin
			pending_d = 1'b0;
			seconds_d = sec_dec;
			case (phase_q)
				tlc_pkg::PH_NS_GO: begin
					if (sec_dec <= {3'b000, ns_yellow_q}) phase_d = tlc_pkg::PH_NS_WARN;
				end
				tlc_pkg::PH_NS_WARN: begin
					if (sec_dec == 7'd0) begin
						phase_d = tlc_pkg::PH_EW_GO;
						seconds_d = tlc_pkg::load_value(ew_green_q, ew_yellow_q);
					end
				end
				tlc_pkg::PH_EW_GO: begin
					if (sec_dec <= {3'b000, ew_yellow_q}) phase_d = tlc_pkg::PH_EW_WARN;
				end
				default: begin
					if (sec_dec == 7'd0) begin
						phase_d = tlc_pkg::PH_NS_GO;
						seconds_d = tlc_pkg::load_value(ns_green_q, ns_yellow_q);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlc_pkg::PH_NS_GO;
			seconds_q <= tlc_pkg::RstSeconds;
			ms_q <= 16'd0;
			blink_cnt_q <= 16'd0;
			blink_q <= 1'b0;
			pending_q <= 1'b0;
			scan_q <= 2'd0;
			emerg_q <= 1'b0;
			key_prev_q <= 1'b0;
			release_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			seconds_q <= seconds_d;
			ms_q <= ms_d;
			blink_cnt_q <= blink_cnt_d;
			blink_q <= blink_d;
			pending_q <= pending_d;
			scan_q <= scan_q + 2'd1;
			emerg_q <= emerg_d;
			key_prev_q <= key;
			release_q <= release_d;
		end
	end

	// result from the state before the update
	tlc_display u_display (
		.seconds_left(seconds_q),
		.units_sel(scan_q[0]),
		.emergency(emerg_q),
		.segments(segments)
	);

	// lamps from low bit: ns red, ns yellow, ns green, ew red, ew yellow, ew green
	always_comb begin
		if (emerg_q) begin
			lamps = 6'b001001;
		end else begin
			case (phase_q)
				tlc_pkg::PH_NS_GO: lamps = 6'b001100;
				tlc_pkg::PH_NS_WARN: lamps = {2'b00, 1'b1, 1'b0, blink_q, 1'b0};
				tlc_pkg::PH_EW_GO: lamps = 6'b100001;
				default: lamps = {1'b0, blink_q, 1'b0, 3'b001};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {1'b0, emerg_q, segments, lamps};
			out_user_q <= scan_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	// emergency result shows both reds and no green or yellow
	a_emerg_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[14]) |->
		(m_tdata[5:0] == 6'b001001 && m_tdata[13:6] == tlc_pkg::SegZero))
		else $error("emergency result lamps or digits wrong");

	// phase and countdown frozen while emergency holds
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		emerg_q |-> ($stable(phase_q) && $stable(seconds_q)))
		else $error("countdown moved in emergency");

	// scan advances by one per transfer
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (scan_q == $past(scan_q) + 2'd1))
		else $error("scan position skipped");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for traffic_light_controller: tick stream in, lamp and digit stream out
// depends on tlc_pkg and the controller rtl; holds its own tick-by-tick prediction of the display
module tb;

	typedef struct packed {
		logic [1:0] sel;
		logic       em_active;
		logic [7:0] segments;
		logic       ew_g;
		logic       ew_y;
		logic       ew_r;
		logic       ns_g;
		logic       ns_y;
		logic       ns_r;
	} display_t;

	typedef struct packed {
		logic     key;
		logic     typed;
		display_t want;
	} tick_row_t;

	localparam logic [5:0] LampsNsGo = 6'b001100;
	localparam logic [5:0] LampsAllRed = 6'b001001;
	localparam logic [7:0] SegTable [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
		8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

	// reset timing; typed rows are read straight off the reset state
	localparam tick_row_t DirRows [20] = '{
		{1'b0, 1'b1, 2'd0, 1'b0, 8'hA4, LampsNsGo},
		{1'b0, 1'b1, 2'd1, 1'b0, 8'hB0, LampsNsGo},
		{1'b0, 1'b1, 2'd2, 1'b0, 8'hA4, LampsNsGo},
		{1'b0, 1'b1, 2'd3, 1'b0, 8'hB0, LampsNsGo},
		{1'b1, 1'b1, 2'd0, 1'b0, 8'hA4, LampsNsGo},
		{1'b1, 1'b1, 2'd1, 1'b1, tlc_pkg::SegZero, LampsAllRed},
		{1'b0, 1'b1, 2'd2, 1'b1, tlc_pkg::SegZero, LampsAllRed},
		{1'b1, 1'b1, 2'd3, 1'b1, tlc_pkg::SegZero, LampsAllRed},
		{1'b0, 1'b1, 2'd0, 1'b0, 8'hA4, LampsNsGo},
		{1'b1, 1'b1, 2'd1, 1'b0, 8'hB0, LampsNsGo},
		{1'b0, 1'b1, 2'd2, 1'b1, tlc_pkg::SegZero, LampsAllRed},
		{1'b0, 1'b0, 17'd0},
		{1'b0, 1'b0, 17'd0},
		{1'b0, 1'b0, 17'd0},
		{1'b0, 1'b0, 17'd0},
		{1'b1, 1'b0, 17'd0},
		{1'b1, 1'b0, 17'd0},
		{1'b0, 1'b0, 17'd0},
		{1'b1, 1'b0, 17'd0},
		{1'b0, 1'b0, 17'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = tlc_pkg::REG_NONE;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	traffic_light_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// timing copy
	logic [6:0]  ns_go_s, ew_go_s;
	logic [3:0]  ns_warn_s, ew_warn_s;
	logic [15:0] tick_sec, tick_blink;
	logic [7:0]  debounce;

	// controller copy
	tlc_pkg::phase_t cur_phase;
	logic [6:0]  secs_left;
	logic [15:0] ms_cnt, blink_cnt;
	logic        blink_on, sec_pending, emerg, key_prev;
	logic [1:0]  digit_pos;
	logic [7:0]  release_cnt;

	display_t due_displays [$];
	bit src_idle, snk_idle;
	int errors, ticks_sent, results_seen, timings, emerg_ticks, phase_changes;

	task automatic report(input string what);
		errors++;
		if (errors <= 40)
			$display("tb: mismatch at result %0d: %s", results_seen, what);
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	function automatic logic [7:0] seg_of(input int unsigned d);
		return d > 9 ? tlc_pkg::SegBlank : SegTable[d];
	endfunction

	function automatic logic [6:0] reload(input logic [6:0] green, input logic [3:0] yellow);
		int unsigned t;
		t = green + yellow;
		return t > 127 ? 7'd127 : t[6:0];
	endfunction

	function automatic display_t lamps_for_tick(input logic key);
		display_t r;
		logic [1:0] pos;
		tlc_pkg::phase_t old;
		r = '0;
		pos = digit_pos;
		old = cur_phase;
		r.sel = pos;
		r.em_active = emerg;
		if (emerg) begin
			r.ns_r = 1'b1;
			r.ew_r = 1'b1;
			r.segments = tlc_pkg::SegZero;
			emerg_ticks++;
		end else begin
			case (cur_phase)
				tlc_pkg::PH_NS_GO: begin
					r.ns_g = 1'b1;
					r.ew_r = 1'b1;
				end
				tlc_pkg::PH_NS_WARN: begin
					r.ew_r = 1'b1;
					r.ns_y = blink_on;
				end
				tlc_pkg::PH_EW_GO: begin
					r.ns_r = 1'b1;
					r.ew_g = 1'b1;
				end
				default: begin
					r.ns_r = 1'b1;
					r.ew_y = blink_on;
				end
			endcase
			r.segments = seg_of(pos[0] ? secs_left % 10 : secs_left / 10);
		end

		digit_pos = pos + 2'd1;
		ms_cnt = ms_cnt + 16'd1;
		if (ms_cnt == 16'd0 || ms_cnt >= tick_sec) begin
			ms_cnt = 16'd0;
			sec_pending = 1'b1;
		end
		blink_cnt = blink_cnt + 16'd1;
		if (blink_cnt == 16'd0 || blink_cnt >= tick_blink) begin
			blink_cnt = 16'd0;
			blink_on = !blink_on;
		end

		if (key && !key_prev) begin
			emerg = !emerg;
			release_cnt = 8'd0;
		end else if (emerg) begin
			if (key) begin
				release_cnt = 8'd0;
			end else begin
				if (release_cnt != 8'd255)
					release_cnt = release_cnt + 8'd1;
				if (release_cnt >= (debounce == 8'd0 ? 8'd1 : debounce)) begin
					emerg = 1'b0;
					release_cnt = 8'd0;
				end
			end
		end else begin
			release_cnt = 8'd0;
		end
		key_prev = key;

		// a second held back by emergency lands on the first tick after it
		if (!emerg && sec_pending) begin
			sec_pending = 1'b0;
			if (secs_left != 7'd0)
				secs_left = secs_left - 7'd1;
			case (cur_phase)
				tlc_pkg::PH_NS_GO: if (secs_left <= ns_warn_s)
					cur_phase = tlc_pkg::PH_NS_WARN;
				tlc_pkg::PH_NS_WARN: if (secs_left == 7'd0) begin
					cur_phase = tlc_pkg::PH_EW_GO;
					secs_left = reload(ew_go_s, ew_warn_s);
				end
				tlc_pkg::PH_EW_GO: if (secs_left <= ew_warn_s)
					cur_phase = tlc_pkg::PH_EW_WARN;
				default: if (secs_left == 7'd0) begin
					cur_phase = tlc_pkg::PH_NS_GO;
					secs_left = reload(ns_go_s, ns_warn_s);
				end
			endcase
		end
		if (cur_phase != old)
			phase_changes++;
		return r;
	endfunction

	task automatic cfg_write(input tlc_pkg::reg_index_t idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			tlc_pkg::REG_NS_GREEN: ns_go_s = value[6:0];
			tlc_pkg::REG_NS_YELLOW: ns_warn_s = value[3:0];
			tlc_pkg::REG_EW_GREEN: ew_go_s = value[6:0];
			tlc_pkg::REG_EW_YELLOW: ew_warn_s = value[3:0];
			tlc_pkg::REG_TICKS_SEC: tick_sec = value;
			tlc_pkg::REG_TICKS_BLINK: tick_blink = value;
			tlc_pkg::REG_DEBOUNCE: debounce = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [15:0] ng, input logic [15:0] ny, input logic [15:0] eg,
		input logic [15:0] ey, input logic [15:0] tps, input logic [15:0] tpb,
		input logic [15:0] deb);
		cfg_write(tlc_pkg::REG_NS_GREEN, ng);
		cfg_write(tlc_pkg::REG_NS_YELLOW, ny);
		cfg_write(tlc_pkg::REG_EW_GREEN, eg);
		cfg_write(tlc_pkg::REG_EW_YELLOW, ey);
		cfg_write(tlc_pkg::REG_TICKS_SEC, tps);
		cfg_write(tlc_pkg::REG_TICKS_BLINK, tpb);
		cfg_write(tlc_pkg::REG_DEBOUNCE, deb);
		@(posedge clk);
		cfg_we <= 1'b0;
		timings++;
	endtask

	task automatic send_tick(input logic key);
		int gap;
		gap = src_idle ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, key};
		do @(posedge clk); while (!s_tready);
		due_displays.push_back(lamps_for_tick(key));
		ticks_sent++;
	endtask

	// hold the tick stream until every display transfer is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_displays.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int gap;
		display_t got, want;
		wait (arst_n);
		forever begin
			gap = snk_idle ? $urandom_range(0, 19) : 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			got = {m_tuser, m_tdata[14:0]};
			if (due_displays.size() == 0) begin
				report("display transfer with nothing expected");
			end else begin
				want = due_displays.pop_front();
				check_field("ns_red_on", 32'(got.ns_r), 32'(want.ns_r));
				check_field("ns_yellow_on", 32'(got.ns_y), 32'(want.ns_y));
				check_field("ns_green_on", 32'(got.ns_g), 32'(want.ns_g));
				check_field("ew_red_on", 32'(got.ew_r), 32'(want.ew_r));
				check_field("ew_yellow_on", 32'(got.ew_y), 32'(want.ew_y));
				check_field("ew_green_on", 32'(got.ew_g), 32'(want.ew_g));
				check_field("segments", 32'(got.segments), 32'(want.segments));
				check_field("emergency_active", 32'(got.em_active), 32'(want.em_active));
				check_field("digit_select", 32'(got.sel), 32'(want.sel));
				check_field("tdata padding", 32'(m_tdata[15]), 0);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		tick_row_t row;
		int unsigned ng, ny, eg, ey, tps, tpb, deb;
		int held;
		ns_go_s = tlc_pkg::RstNsGreen;
		ns_warn_s = tlc_pkg::RstNsYellow;
		ew_go_s = tlc_pkg::RstEwGreen;
		ew_warn_s = tlc_pkg::RstEwYellow;
		tick_sec = tlc_pkg::RstTicksSec;
		tick_blink = tlc_pkg::RstTicksBlink;
		debounce = tlc_pkg::RstDebounce;
		cur_phase = tlc_pkg::PH_NS_GO;
		secs_left = tlc_pkg::RstSeconds;
		ms_cnt = 16'd0;
		blink_cnt = 16'd0;
		blink_on = 1'b0;
		sec_pending = 1'b0;
		emerg = 1'b0;
		key_prev = 1'b0;
		digit_pos = 2'd0;
		release_cnt = 8'd0;
		held = 0;
		src_idle = ($urandom_range(0, 1) == 1);
		snk_idle = ($urandom_range(0, 1) == 1);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 20; i++) begin
			row = DirRows[i];
			send_tick(row.key);
			if (row.typed)
				due_displays[due_displays.size() - 1] = row.want;
		end
		settle();

		for (int p = 0; p < 13; p++) begin
			if (p == 0) begin
				set_timing(16'd90, 16'd9, 16'd90, 16'd9, 16'd65535, 16'd65535, 16'd255);
			end else if (p == 1) begin
				set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
			end else if (p == 2) begin
				// masked and out-of-range values: long reload, blank tens, every-tick dividers
				set_timing(16'hFFFF, 16'hFFFF, 16'h0080, 16'h0010, 16'h0000, 16'h0001, 16'hFF00);
			end else begin
				ng = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 8);
				ny = $urandom_range(1, 9);
				eg = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 8);
				ey = $urandom_range(1, 9);
				tps = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 65535) : $urandom_range(2, 6);
				tpb = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 5);
				deb = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 15);
				set_timing(16'(ng), 16'(ny), 16'(eg), 16'(ey), 16'(tps), 16'(tpb), 16'(deb));
			end
			src_idle = $urandom_range(0, 2) != 0;
			snk_idle = $urandom_range(0, 2) != 0;
			for (int i = 0; i < 40; i++) begin
				if (held == 0 && $urandom_range(0, 11) == 0)
					held = $urandom_range(1, 4);
				if (held != 0) begin
					held--;
					send_tick(1'b1);
				end else begin
					send_tick(1'b0);
				end
			end
			settle();
		end

		$display("tb: %0d ticks over %0d timing settings, %0d display transfers checked",
			ticks_sent, timings, results_seen);
		$display("tb: %0d ticks shown in emergency all-red, %0d phase changes", emerg_ticks,
			phase_changes);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
